[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/gcbd_pkg.sv]
// Shared types, command codes and hat tables for the gamepad command decoder.
// No dependencies.
package gcbd_pkg;

  localparam int unsigned NUM_BUTTONS = 9;
  localparam int unsigned NUM_AXES    = 4;

  localparam logic [3:0] HAT_NEUTRAL = 4'd8;

  localparam logic [7:0] AXIS_MIN    = 8'd0;
  localparam logic [7:0] AXIS_CENTER = 8'd128;
  localparam logic [7:0] AXIS_MAX    = 8'd255;

  // Direction bits: up, right, down, left
  localparam logic [3:0] DIR_UP    = 4'h8;
  localparam logic [3:0] DIR_RIGHT = 4'h4;
  localparam logic [3:0] DIR_DOWN  = 4'h2;
  localparam logic [3:0] DIR_LEFT  = 4'h1;

  localparam logic [1:0] AXIS_LX = 2'd0;
  localparam logic [1:0] AXIS_LY = 2'd1;
  localparam logic [1:0] AXIS_RX = 2'd2;
  localparam logic [1:0] AXIS_RY = 2'd3;

  // Command characters
  localparam logic [7:0] CMD_HOME      = 8'h40; // '@'
  localparam logic [7:0] CMD_PRESS_LO  = 8'h61; // 'a'
  localparam logic [7:0] CMD_PRESS_HI  = 8'h68; // 'h'
  localparam logic [7:0] CMD_REL_LO    = 8'h6D; // 'm'
  localparam logic [7:0] CMD_REL_HI    = 8'h74; // 't'
  localparam logic [7:0] CMD_SET_LEFT  = 8'h69; // 'i'
  localparam logic [7:0] CMD_SET_RIGHT = 8'h6A; // 'j'
  localparam logic [7:0] CMD_SET_DOWN  = 8'h6B; // 'k'
  localparam logic [7:0] CMD_SET_UP    = 8'h6C; // 'l'
  localparam logic [7:0] CMD_CLR_LEFT  = 8'h75; // 'u'
  localparam logic [7:0] CMD_CLR_RIGHT = 8'h76; // 'v'
  localparam logic [7:0] CMD_CLR_DOWN  = 8'h77; // 'w'
  localparam logic [7:0] CMD_CLR_UP    = 8'h78; // 'x'
  localparam logic [7:0] CMD_LX_MIN    = 8'h79; // 'y'
  localparam logic [7:0] CMD_LX_MID    = 8'h7A; // 'z'
  localparam logic [7:0] CMD_LX_MAX    = 8'h31; // '1'
  localparam logic [7:0] CMD_LY_MIN    = 8'h32;
  localparam logic [7:0] CMD_LY_MID    = 8'h33;
  localparam logic [7:0] CMD_LY_MAX    = 8'h34;
  localparam logic [7:0] CMD_RX_MIN    = 8'h35;
  localparam logic [7:0] CMD_RX_MID    = 8'h36;
  localparam logic [7:0] CMD_RX_MAX    = 8'h37;
  localparam logic [7:0] CMD_RY_MIN    = 8'h38;
  localparam logic [7:0] CMD_RY_MID    = 8'h39;
  localparam logic [7:0] CMD_RY_MAX    = 8'h30; // '0'

  typedef enum logic [2:0] {
    OP_REJECT  = 3'd0,
    OP_HOME    = 3'd1,
    OP_PRESS   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_DIR_SET = 3'd4,
    OP_DIR_CLR = 3'd5,
    OP_AXIS    = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] btn_sel;   // button index 1..8
    logic [3:0] dir_mask;
    logic [1:0] axis_sel;
    logic [7:0] level;
  } cmd_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]     buttons;
    logic [3:0]                 hat;
    logic [NUM_AXES-1:0][7:0]   axes;
  } pad_state_t;

  function automatic logic [3:0] hat_to_dirs(input logic [3:0] hat);
    logic [3:0] d;
    unique case (hat)
      4'd0:    d = 4'h8;
      4'd1:    d = 4'hC;
      4'd2:    d = 4'h4;
      4'd3:    d = 4'h6;
      4'd4:    d = 4'h2;
      4'd5:    d = 4'h3;
      4'd6:    d = 4'h1;
      4'd7:    d = 4'h9;
      default: d = 4'h0; // neutral and unreachable codes
    endcase
    return d;
  endfunction

  // Contradictory or empty direction sets give neutral.
  function automatic logic [3:0] dirs_to_hat(input logic [3:0] d);
    logic [3:0] h;
    unique case (d)
      4'h8:    h = 4'd0;
      4'hC:    h = 4'd1;
      4'h4:    h = 4'd2;
      4'h6:    h = 4'd3;
      4'h2:    h = 4'd4;
      4'h3:    h = 4'd5;
      4'h1:    h = 4'd6;
      4'h9:    h = 4'd7;
      default: h = HAT_NEUTRAL;
    endcase
    return h;
  endfunction

endpackage

[rtl/gcbd_decode.sv]
// Command byte decoder: maps one byte to an operation descriptor.
// Depends on gcbd_pkg.
module gcbd_decode (
  input  logic [7:0]    cmd_byte,
  output gcbd_pkg::cmd_t cmd
);
  import gcbd_pkg::*;

  logic [7:0] press_ofs;
  logic [7:0] rel_ofs;

  assign press_ofs = cmd_byte - CMD_PRESS_LO + 8'd1;
  assign rel_ofs   = cmd_byte - CMD_REL_LO + 8'd1;

  always_comb begin
    cmd.op       = OP_REJECT;
    cmd.btn_sel  = '0;
    cmd.dir_mask = '0;
    cmd.axis_sel = AXIS_LX;
    cmd.level    = AXIS_CENTER;
    priority if (cmd_byte == CMD_HOME) begin
      cmd.op = OP_HOME;
    end else if (cmd_byte >= CMD_PRESS_LO && cmd_byte <= CMD_PRESS_HI) begin
      cmd.op      = OP_PRESS;
      cmd.btn_sel = press_ofs[3:0];
    end else if (cmd_byte >= CMD_REL_LO && cmd_byte <= CMD_REL_HI) begin
      cmd.op      = OP_RELEASE;
      cmd.btn_sel = rel_ofs[3:0];
    end else begin
      unique case (cmd_byte)
        CMD_SET_LEFT:  begin cmd.op = OP_DIR_SET; cmd.dir_mask = DIR_LEFT;  end
        CMD_SET_RIGHT: begin cmd.op = OP_DIR_SET; cmd.dir_mask = DIR_RIGHT; end
        CMD_SET_DOWN:  begin cmd.op = OP_DIR_SET; cmd.dir_mask = DIR_DOWN;  end
        CMD_SET_UP:    begin cmd.op = OP_DIR_SET; cmd.dir_mask = DIR_UP;    end
        CMD_CLR_LEFT:  begin cmd.op = OP_DIR_CLR; cmd.dir_mask = DIR_LEFT;  end
        CMD_CLR_RIGHT: begin cmd.op = OP_DIR_CLR; cmd.dir_mask = DIR_RIGHT; end
        CMD_CLR_DOWN:  begin cmd.op = OP_DIR_CLR; cmd.dir_mask = DIR_DOWN;  end
        CMD_CLR_UP:    begin cmd.op = OP_DIR_CLR; cmd.dir_mask = DIR_UP;    end
        CMD_LX_MIN: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LX; cmd.level = AXIS_MIN;    end
        CMD_LX_MID: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LX; cmd.level = AXIS_CENTER; end
        CMD_LX_MAX: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LX; cmd.level = AXIS_MAX;    end
        CMD_LY_MIN: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LY; cmd.level = AXIS_MIN;    end
        CMD_LY_MID: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LY; cmd.level = AXIS_CENTER; end
        CMD_LY_MAX: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_LY; cmd.level = AXIS_MAX;    end
        CMD_RX_MIN: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RX; cmd.level = AXIS_MIN;    end
        CMD_RX_MID: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RX; cmd.level = AXIS_CENTER; end
        CMD_RX_MAX: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RX; cmd.level = AXIS_MAX;    end
        CMD_RY_MIN: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RY; cmd.level = AXIS_MIN;    end
        CMD_RY_MID: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RY; cmd.level = AXIS_CENTER; end
        CMD_RY_MAX: begin cmd.op = OP_AXIS; cmd.axis_sel = AXIS_RY; cmd.level = AXIS_MAX;    end
        default:    cmd.op = OP_REJECT;
      endcase
    end
  end

endmodule

[rtl/gcbd_state.sv]
// Held gamepad state registers and their update from one decoded command.
// Depends on gcbd_pkg.
module gcbd_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  apply,
  input  gcbd_pkg::cmd_t        cmd,
  output gcbd_pkg::pad_state_t  state_nxt
);
  import gcbd_pkg::*;

  logic [NUM_BUTTONS-1:0]   buttons_r;
  logic [3:0]               hat_r;
  logic [NUM_AXES-1:0][7:0] axes_r;

  logic [NUM_BUTTONS-1:0]   btn_w;
  logic [3:0]               dirs_w;
  logic [NUM_AXES-1:0][7:0] axes_w;

  always_comb begin
    btn_w  = buttons_r;
    dirs_w = hat_to_dirs(hat_r);
    axes_w = axes_r;
    // any accepted byte but home releases home
    if (cmd.op != OP_REJECT && cmd.op != OP_HOME) begin
      btn_w[0] = 1'b0;
    end
    unique case (cmd.op)
      OP_REJECT:  ;
      OP_HOME:    btn_w[0] = 1'b1;
      OP_PRESS:   btn_w[cmd.btn_sel] = 1'b1;
      OP_RELEASE: btn_w[cmd.btn_sel] = 1'b0;
      OP_DIR_SET: dirs_w = dirs_w | cmd.dir_mask;
      OP_DIR_CLR: dirs_w = dirs_w & ~cmd.dir_mask;
      OP_AXIS:    axes_w[cmd.axis_sel] = cmd.level;
      default:    ;
    endcase
    state_nxt.buttons = btn_w;
    state_nxt.hat     = (cmd.op == OP_REJECT) ? hat_r : dirs_to_hat(dirs_w);
    state_nxt.axes    = axes_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r <= '0;
      hat_r     <= HAT_NEUTRAL;
      axes_r    <= {NUM_AXES{AXIS_CENTER}};
    end else if (apply) begin
      buttons_r <= state_nxt.buttons;
      hat_r     <= state_nxt.hat;
      axes_r    <= state_nxt.axes;
    end
  end

endmodule

[rtl/gamepad_command_byte_decoder.sv]
// Top level of the gamepad command byte decoder: input register, decode,
// state update and result register. Depends on gcbd_pkg, gcbd_decode,
// gcbd_state and assert_macros.svh.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | in_command_byte
//  out     | output    | out_valid / out_ready | accepted, buttons, hat, sticks
//
// One word per cycle sustained while out_ready is high; a taken byte moves from
// the input register to the result register when it is empty or being drained.
// Decode and state update sit in the single path between the two registers.
// Reset (rst_n low, synchronous) empties both registers, releases all
// buttons, sets the hat neutral and centers all sticks.
// A stalled output holds its word; the input register keeps filling behind
// it and in_ready drops only when both registers are full and out_ready is low.
`include "assert_macros.svh"

module gamepad_command_byte_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_command_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic [8:0] out_button_bits,
  output logic [3:0] out_hat_dir,
  output logic [7:0] out_left_x,
  output logic [7:0] out_left_y,
  output logic [7:0] out_right_x,
  output logic [7:0] out_right_y
);
  import gcbd_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       out_acc_r;
  pad_state_t out_state_r;

  logic       in_take;
  logic       out_load;
  cmd_t       cmd;
  pad_state_t state_nxt;

  // terms for the checks at the end
  logic       rej_load;
  logic       drop_home;

  // the result register moves on when empty or being drained
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign in_take  = in_valid && in_ready;

  gcbd_decode u_decode (
    .cmd_byte (s1_byte_r),
    .cmd      (cmd)
  );

  // state commits exactly when the word moves into the result register
  gcbd_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .apply     (out_load),
    .cmd       (cmd),
    .state_nxt (state_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_command_byte;
    end
    if (out_load) begin
      out_acc_r   <= (cmd.op != OP_REJECT);
      out_state_r <= state_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_button_bits = out_state_r.buttons;
  assign out_hat_dir     = out_state_r.hat;
  assign out_left_x      = out_state_r.axes[AXIS_LX];
  assign out_left_y      = out_state_r.axes[AXIS_LY];
  assign out_right_x     = out_state_r.axes[AXIS_RX];
  assign out_right_y     = out_state_r.axes[AXIS_RY];

  assign rej_load  = out_load && out_valid_r && cmd.op == OP_REJECT;
  assign drop_home = out_load && cmd.op != OP_REJECT && cmd.op != OP_HOME;

  // hat never leaves the nine legal codes
  `ASSERT_IMPLIES(a_hat_range, clk, rst_n, out_valid_r, out_hat_dir <= HAT_NEUTRAL, "hat range")
  // a rejected word leaves the reported state untouched
  `ASSERT_NEXT(a_reject_holds, clk, rst_n, rej_load, $stable(out_state_r), "reject changed state")
  // an empty input register always takes a word
  `ASSERT_IMPLIES(a_ready_empty, clk, rst_n, !s1_valid_r, in_ready, "input stalled while empty")
  // accepted non-home words release home
  `ASSERT_NEXT(a_home_clear, clk, rst_n, drop_home, !out_state_r.buttons[0], "home not released")

endmodule

[test/gamepad_state_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the gamepad command byte decoder: tracks the pad state per
// accepted byte and checks every result word. Depends on gcbd_pkg.
module gamepad_state_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_command_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_accepted,
  input  logic [8:0] out_button_bits,
  input  logic [3:0] out_hat_dir,
  input  logic [7:0] out_left_x,
  input  logic [7:0] out_left_y,
  input  logic [7:0] out_right_x,
  input  logic [7:0] out_right_y,
  output int         fail_count,
  output int         words_pending
);
  import gcbd_pkg::*;

  // hat encoding
  localparam logic [3:0] HAT_UP        = 4'd0;
  localparam logic [3:0] HAT_UPRIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT     = 4'd2;
  localparam logic [3:0] HAT_DOWNRIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN      = 4'd4;
  localparam logic [3:0] HAT_DOWNLEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT      = 4'd6;
  localparam logic [3:0] HAT_UPLEFT    = 4'd7;

  typedef struct packed {
    logic       accepted;
    logic [8:0] buttons;
    logic [3:0] hat;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
  } pad_word_t;

  logic [8:0] pad_buttons;
  logic [3:0] pad_hat;
  logic [7:0] pad_axes [NUM_AXES];
  pad_word_t  expected_words [$];

  function automatic logic [3:0] dirs_of_hat(input logic [3:0] hat);
    case (hat)
      HAT_UP:        return DIR_UP;
      HAT_UPRIGHT:   return DIR_UP | DIR_RIGHT;
      HAT_RIGHT:     return DIR_RIGHT;
      HAT_DOWNRIGHT: return DIR_DOWN | DIR_RIGHT;
      HAT_DOWN:      return DIR_DOWN;
      HAT_DOWNLEFT:  return DIR_DOWN | DIR_LEFT;
      HAT_LEFT:      return DIR_LEFT;
      HAT_UPLEFT:    return DIR_UP | DIR_LEFT;
      default:       return 4'h0;
    endcase
  endfunction

  // opposing pairs and the empty set fold to neutral
  function automatic logic [3:0] hat_of_dirs(input logic [3:0] dirs);
    logic up, rt, dn, lf;
    up = |(dirs & DIR_UP);
    rt = |(dirs & DIR_RIGHT);
    dn = |(dirs & DIR_DOWN);
    lf = |(dirs & DIR_LEFT);
    if ((up && dn) || (lf && rt) || dirs == 4'h0) return HAT_NEUTRAL;
    if (up) return rt ? HAT_UPRIGHT : (lf ? HAT_UPLEFT : HAT_UP);
    if (dn) return rt ? HAT_DOWNRIGHT : (lf ? HAT_DOWNLEFT : HAT_DOWN);
    return rt ? HAT_RIGHT : HAT_LEFT;
  endfunction

  function automatic logic is_command(input logic [7:0] c);
    return c == CMD_HOME || (c >= CMD_PRESS_LO && c <= CMD_LX_MID) ||
           (c >= CMD_RY_MAX && c <= CMD_RY_MID);
  endfunction

  // apply one byte to the tracked pad and return the word it should produce
  function automatic pad_word_t apply_command(input logic [7:0] c);
    logic [3:0] dirs;
    pad_word_t  w;
    w.accepted = is_command(c);
    if (w.accepted) begin
      dirs = dirs_of_hat(pad_hat);
      if (c != CMD_HOME) pad_buttons[0] = 1'b0;
      if (c == CMD_HOME) begin
        pad_buttons[0] = 1'b1;
      end else if (c >= CMD_PRESS_LO && c <= CMD_PRESS_HI) begin
        pad_buttons[c - CMD_PRESS_LO + 1] = 1'b1;
      end else if (c >= CMD_REL_LO && c <= CMD_REL_HI) begin
        pad_buttons[c - CMD_REL_LO + 1] = 1'b0;
      end else begin
        case (c)
          CMD_SET_LEFT:  dirs = dirs | DIR_LEFT;
          CMD_SET_RIGHT: dirs = dirs | DIR_RIGHT;
          CMD_SET_DOWN:  dirs = dirs | DIR_DOWN;
          CMD_SET_UP:    dirs = dirs | DIR_UP;
          CMD_CLR_LEFT:  dirs = dirs & ~DIR_LEFT;
          CMD_CLR_RIGHT: dirs = dirs & ~DIR_RIGHT;
          CMD_CLR_DOWN:  dirs = dirs & ~DIR_DOWN;
          CMD_CLR_UP:    dirs = dirs & ~DIR_UP;
          CMD_LX_MIN:    pad_axes[AXIS_LX] = AXIS_MIN;
          CMD_LX_MID:    pad_axes[AXIS_LX] = AXIS_CENTER;
          CMD_LX_MAX:    pad_axes[AXIS_LX] = AXIS_MAX;
          CMD_LY_MIN:    pad_axes[AXIS_LY] = AXIS_MIN;
          CMD_LY_MID:    pad_axes[AXIS_LY] = AXIS_CENTER;
          CMD_LY_MAX:    pad_axes[AXIS_LY] = AXIS_MAX;
          CMD_RX_MIN:    pad_axes[AXIS_RX] = AXIS_MIN;
          CMD_RX_MID:    pad_axes[AXIS_RX] = AXIS_CENTER;
          CMD_RX_MAX:    pad_axes[AXIS_RX] = AXIS_MAX;
          CMD_RY_MIN:    pad_axes[AXIS_RY] = AXIS_MIN;
          CMD_RY_MID:    pad_axes[AXIS_RY] = AXIS_CENTER;
          CMD_RY_MAX:    pad_axes[AXIS_RY] = AXIS_MAX;
          default: ;
        endcase
      end
      // every accepted byte rebuilds the hat, even a button command
      pad_hat = hat_of_dirs(dirs);
    end
    w.buttons = pad_buttons;
    w.hat     = pad_hat;
    w.left_x  = pad_axes[AXIS_LX];
    w.left_y  = pad_axes[AXIS_LY];
    w.right_x = pad_axes[AXIS_RX];
    w.right_y = pad_axes[AXIS_RY];
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pad_word_t want;
    if (!rst_n) begin
      pad_buttons = '0;
      pad_hat     = HAT_NEUTRAL;
      for (int i = 0; i < NUM_AXES; i++) pad_axes[i] = AXIS_CENTER;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) expected_words.push_back(apply_command(in_command_byte));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, actual accepted %0b",
                   $time, out_accepted);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("accepted", want.accepted, out_accepted);
          compare_field("button_bits", want.buttons, out_button_bits);
          compare_field("hat_dir", want.hat, out_hat_dir);
          compare_field("left_x", want.left_x, out_left_x);
          compare_field("left_y", want.left_y, out_left_y);
          compare_field("right_x", want.right_x, out_right_x);
          compare_field("right_y", want.right_y, out_right_y);
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, byte stimulus, output stalls
// and the verdict. Depends on gcbd_pkg, the decoder RTL and gamepad_state_checker.
module testbench;
  import gcbd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_command_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_accepted;
  logic [8:0] out_button_bits;
  logic [3:0] out_hat_dir;
  logic [7:0] out_left_x;
  logic [7:0] out_left_y;
  logic [7:0] out_right_x;
  logic [7:0] out_right_y;
  int         fail_count;
  int         words_pending;

  // sender gaps are switched off for one long stretch of the random part
  bit         sender_idles = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gamepad_command_byte_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command_byte (in_command_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_button_bits (out_button_bits),
    .out_hat_dir     (out_hat_dir),
    .out_left_x      (out_left_x),
    .out_left_y      (out_left_y),
    .out_right_x     (out_right_x),
    .out_right_y     (out_right_y)
  );

  gamepad_state_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command_byte (in_command_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_button_bits (out_button_bits),
    .out_hat_dir     (out_hat_dir),
    .out_left_x      (out_left_x),
    .out_left_y      (out_left_y),
    .out_right_x     (out_right_x),
    .out_right_y     (out_right_y),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  // Called at a rising edge; returns at the edge where the word is taken.
  // A gap drops valid for whole cycles only, never inside a held offer.
  task automatic send_word(input logic [7:0] b);
    while (sender_idles && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // k = 0 is home, 1..26 the letters, 27..36 the digits
  function automatic logic [7:0] pick_command(input int k);
    if (k == 0) return CMD_HOME;
    if (k <= 26) return 8'(CMD_PRESS_LO + k - 1);
    return 8'(CMD_RY_MAX + k - 27);  // CMD_RY_MAX is the digit zero
  endfunction

  // Receiver: random stalls, a clean stretch, and one long hold-off that
  // lets both registers fill so in_ready has to drop.
  initial begin
    int cycle;
    cycle = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == 400) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (cycle >= 150 && cycle < 300) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL gamepad_command_byte_decoder");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and rejects around the accepted ranges.
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h60);           // just below the letters
    send_word(8'h7B);           // just above the letters
    send_word(8'h2F);           // just below the digits
    send_word(8'h3A);           // just above the digits
    send_word(8'h41);           // uppercase, just above home
    // home is held by its own command and dropped by the next accepted one
    send_word(CMD_HOME);
    send_word(CMD_PRESS_LO);
    send_word(CMD_HOME);
    send_word(8'h3F);           // rejected byte keeps home pressed
    send_word(CMD_PRESS_HI);
    send_word(CMD_REL_LO);
    send_word(CMD_REL_HI);
    // hat: up, upright, then down too gives neutral and loses every bit
    send_word(CMD_SET_UP);
    send_word(CMD_SET_RIGHT);
    send_word(CMD_SET_DOWN);
    send_word(CMD_SET_LEFT);
    send_word(CMD_SET_DOWN);
    send_word(CMD_CLR_UP);
    send_word(CMD_CLR_LEFT);
    send_word(CMD_CLR_DOWN);
    // stick extremes
    send_word(CMD_LX_MIN);
    send_word(CMD_LY_MAX);
    send_word(CMD_RX_MIN);
    send_word(CMD_RY_MAX);

    // Random: mostly real commands so the state wanders, the rest any byte.
    for (int i = 0; i < 550; i++) begin
      sender_idles = !(i >= 300 && i < 420);
      if ($urandom_range(99) < 75) send_word(pick_command($urandom_range(36)));
      else send_word(8'($urandom_range(255)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (words_pending == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS gamepad_command_byte_decoder");
    end else begin
      $display("FAIL gamepad_command_byte_decoder");
    end
    $finish;
  end

endmodule
